@@ rtl/core/rpcn_pkg.sv @@
// Shared types, codes and constants of the cosine-neighbor rating predictor
`default_nettype none
package rpcn_pkg;

    // Default store geometry
    localparam int DEF_MAX_USERS = 16;
    localparam int DEF_MAX_ITEMS = 16;

    // Fixed field widths
    localparam int RATING_W = 4;
    localparam int INDEX_W  = 4;
    localparam int THR_W    = 16;
    localparam int CNT_CFG_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PRED_W   = 14;
    localparam int SIM_W    = 16;
    localparam int MEAN_W   = 12;
    localparam int CMP_W    = 9;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_USERS     = 2'd1,
        CFG_ITEMS     = 2'd2
    } cfg_idx_t;

    // Input action codes
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_PREDICT = 1'b1;

    // Accumulate mode applied in the cycle after a read
    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_ROW  = 2'd1,
        ACC_PAIR = 2'd2,
        ACC_RW   = 2'd3
    } acc_t;

    // Divider operand select
    typedef enum logic [1:0] {
        DIV_MEAN_U = 2'd0,
        DIV_MEAN_R = 2'd1,
        DIV_FINAL  = 2'd2
    } div_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     wr_en;
        acc_t     acc;
        logic     clr_u;
        logic     clr_r;
        logic     clr_pred;
        logic     prep;
        logic     sq_mul;
        logic     sq_lhs;
        logic     sq_cmp;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_u;
        logic     take_r;
        logic     mac;
        logic     acc_num;
        logic     fin;
        logic     out_zero;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic su_zero;
        logic rw_zero;
        logic sim_gt;
        logic used;
        logic div_done;
        logic div_busy;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/core/rating_prediction_cosine_neighbors_unit.sv @@
// Top level of the cosine-neighbor rating predictor
`default_nettype none
// Command-style block: an item is taken when start is high and busy is low;
// the single predict result appears for one cycle with result_valid and must
// be captured then, since the receiver cannot hold it off. After reset the
// block sweeps the rating memory to zero, one entry per cycle, with busy
// high. A rating write leaves busy low. A predict walks row u, then for each
// other user that rated the item: a pair pass over the row, a 16-bit
// similarity search that squares, multiplies and compares for each bit, and,
// if the similarity beats the threshold, a mean division on the shared
// restoring divider (one bit per cycle). A last division gives the weighted
// mean. Predict time is bounded by the divider and the similarity search.
// Configuration transfers are always ready.
module rating_prediction_cosine_neighbors_unit
    import rpcn_pkg::*;
#(
    parameter int MAX_USERS = DEF_MAX_USERS,
    parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  action,
    input  wire logic [INDEX_W-1:0]    user,
    input  wire logic [INDEX_W-1:0]    item,
    input  wire logic [RATING_W-1:0]   rating,
    output logic                       result_valid,
    output logic signed [PRED_W-1:0]   prediction,
    output logic                       available,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int RW = $clog2(MAX_USERS);
    localparam int CW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    // Configuration registers
    logic [THR_W-1:0]     thr_reg;
    logic [CNT_CFG_W-1:0] users_reg;
    logic [CNT_CFG_W-1:0] items_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= '0;
            users_reg <= CNT_CFG_W'(16);
            items_reg <= CNT_CFG_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD: thr_reg   <= cfg_data;
                CFG_USERS:     users_reg <= cfg_data[CNT_CFG_W-1:0];
                CFG_ITEMS:     items_reg <= cfg_data[CNT_CFG_W-1:0];
                default:       thr_reg   <= thr_reg;
            endcase
        end
    end

    cmd_t            cmd;
    status_t         status;
    logic [RW-1:0]   rd_row_a;
    logic [CW-1:0]   rd_col_a;
    logic [RW-1:0]   rd_row_b;
    logic [CW-1:0]   rd_col_b;
    logic [RW-1:0]   wr_row;
    logic [CW-1:0]   wr_col;
    logic [RATING_W-1:0] wr_data;
    logic [3:0]      sq_bit;

    rpcn_ctrl #(
        .MAX_USERS (MAX_USERS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .user         (user),
        .item         (item),
        .rating       (rating),
        .users_in_use (users_reg),
        .items_in_use (items_reg),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd),
        .status       (status),
        .rd_row_a     (rd_row_a),
        .rd_col_a     (rd_col_a),
        .rd_row_b     (rd_row_b),
        .rd_col_b     (rd_col_b),
        .wr_row       (wr_row),
        .wr_col       (wr_col),
        .wr_data      (wr_data),
        .sq_bit       (sq_bit)
    );

    rpcn_datapath #(
        .MAX_USERS (MAX_USERS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .rd_row_a   (rd_row_a),
        .rd_col_a   (rd_col_a),
        .rd_row_b   (rd_row_b),
        .rd_col_b   (rd_col_b),
        .wr_row     (wr_row),
        .wr_col     (wr_col),
        .wr_data    (wr_data),
        .sq_bit     (sq_bit),
        .threshold  (thr_reg),
        .prediction (prediction),
        .available  (available)
    );
endmodule
`default_nettype wire

@@ rtl/core/rpcn_div.sv @@
// Iterative restoring divider, one quotient bit per cycle
`default_nettype none
module rpcn_div
    import rpcn_pkg::*;
#(
    parameter int DV_W = 34
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [DV_W-1:0] dividend,
    input  wire logic [DV_W-1:0] divisor,
    output logic      [DV_W-1:0] quotient,
    output logic                 rem_nz,
    output logic                 done,
    output logic                 busy
);
    localparam int CNT_W = $clog2(DV_W + 1);

    logic [DV_W:0]    rem_reg;
    logic [DV_W-1:0]  quo_reg;
    logic [DV_W-1:0]  dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DV_W:0]    rem_sh;
    logic [DV_W:0]    rem_sub;
    logic             fits;

    // One shift-subtract step
    always_comb
    begin
        rem_sh  = {rem_reg[DV_W-1:0], quo_reg[DV_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        fits    = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub : rem_sh;
            quo_reg <= {quo_reg[DV_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);
    assign done     = done_reg;
    assign busy     = busy_reg;
endmodule
`default_nettype wire

@@ rtl/core/rpcn_datapath.sv @@
// Rating store, row accumulators, similarity search and weighted sums
`default_nettype none
module rpcn_datapath
    import rpcn_pkg::*;
#(
    parameter int MAX_USERS = DEF_MAX_USERS,
    parameter int MAX_ITEMS = DEF_MAX_ITEMS,
    localparam int RW = $clog2(MAX_USERS),
    localparam int CW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output status_t                  status,
    input  wire logic [RW-1:0]       rd_row_a,
    input  wire logic [CW-1:0]       rd_col_a,
    input  wire logic [RW-1:0]       rd_row_b,
    input  wire logic [CW-1:0]       rd_col_b,
    input  wire logic [RW-1:0]       wr_row,
    input  wire logic [CW-1:0]       wr_col,
    input  wire logic [RATING_W-1:0] wr_data,
    input  wire logic [3:0]          sq_bit,
    input  wire logic [THR_W-1:0]    threshold,
    output logic signed [PRED_W-1:0] prediction,
    output logic                     available
);
    localparam int DEPTH  = MAX_USERS * MAX_ITEMS;
    localparam int AW     = $clog2(DEPTH);
    localparam int IW     = $clog2(MAX_ITEMS + 1);
    localparam int UW     = $clog2(MAX_USERS + 1);
    localparam int SUM_W  = RATING_W + IW;
    localparam int SQ_W   = 2 * RATING_W + IW;
    localparam int PROD_W = 2 * SQ_W;
    localparam int RHS_W  = 2 * SQ_W + 30;
    localparam int LHS_W  = 32 + 2 * SQ_W;
    localparam int TERM_W = 30;
    localparam int NUM_W  = TERM_W + UW;
    localparam int DEN_W  = SIM_W + UW;
    localparam int DV_W   = NUM_W;

    // Rating memory: one write port, two registered read ports
    logic [RATING_W-1:0] mem [DEPTH];
    logic [RATING_W-1:0] rdata_a_reg;
    logic [RATING_W-1:0] rdata_b_reg;
    logic [AW-1:0]       addr_a;
    logic [AW-1:0]       addr_b;
    logic [AW-1:0]       addr_w;

    assign addr_a = AW'(rd_row_a) * AW'(MAX_ITEMS) + AW'(rd_col_a);
    assign addr_b = AW'(rd_row_b) * AW'(MAX_ITEMS) + AW'(rd_col_b);
    assign addr_w = AW'(wr_row) * AW'(MAX_ITEMS) + AW'(wr_col);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr_w] <= wr_data;
        end
        rdata_a_reg <= mem[addr_a];
        rdata_b_reg <= mem[addr_b];
    end

    // Accumulate mode follows the read in the next cycle
    acc_t acc_pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_pipe_reg <= ACC_NONE;
        end
        else
        begin
            acc_pipe_reg <= cmd.acc;
        end
    end

    // Row statistics
    logic [SQ_W-1:0]     su_reg;
    logic [SUM_W-1:0]    sumu_reg;
    logic [IW-1:0]       cntu_reg;
    logic [SQ_W-1:0]     dot_reg;
    logic [SQ_W-1:0]     sr_reg;
    logic [SUM_W-1:0]    sumr_reg;
    logic [IW-1:0]       cntr_reg;
    logic [RATING_W-1:0] rw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_u)
        begin
            su_reg   <= '0;
            sumu_reg <= '0;
            cntu_reg <= '0;
        end
        else if (acc_pipe_reg == ACC_ROW)
        begin
            su_reg   <= su_reg + SQ_W'(rdata_a_reg * rdata_a_reg);
            sumu_reg <= sumu_reg + SUM_W'(rdata_a_reg);
            cntu_reg <= cntu_reg + IW'(rdata_a_reg != '0);
        end

        if (cmd.clr_r)
        begin
            dot_reg  <= '0;
            sr_reg   <= '0;
            sumr_reg <= '0;
            cntr_reg <= '0;
        end
        else if (acc_pipe_reg == ACC_PAIR)
        begin
            dot_reg  <= dot_reg + SQ_W'(rdata_a_reg * rdata_b_reg);
            sr_reg   <= sr_reg + SQ_W'(rdata_b_reg * rdata_b_reg);
            sumr_reg <= sumr_reg + SUM_W'(rdata_b_reg);
            cntr_reg <= cntr_reg + IW'(rdata_b_reg != '0);
        end

        if (acc_pipe_reg == ACC_RW)
        begin
            rw_reg <= rdata_b_reg;
        end
    end

    // Bit-serial cosine search: largest s with s*s*su*sr <= dot*dot*2^30
    logic [PROD_W-1:0] prod_reg;
    logic [RHS_W-1:0]  rhs_reg;
    logic [SIM_W-1:0]  s_reg;
    logic [31:0]       csq_reg;
    logic [LHS_W-1:0]  lhs_reg;
    logic [SIM_W-1:0]  cand;

    assign cand = s_reg | (SIM_W'(1) << sq_bit);

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            prod_reg <= PROD_W'(su_reg) * PROD_W'(sr_reg);
            rhs_reg  <= RHS_W'(PROD_W'(dot_reg) * PROD_W'(dot_reg)) << 30;
            s_reg    <= '0;
        end
        else if (cmd.sq_cmp)
        begin
            if (lhs_reg <= LHS_W'(rhs_reg))
            begin
                s_reg <= cand;
            end
        end
        if (cmd.sq_mul)
        begin
            csq_reg <= 32'(cand) * 32'(cand);
        end
        if (cmd.sq_lhs)
        begin
            lhs_reg <= LHS_W'(csq_reg) * LHS_W'(prod_reg);
        end
    end

    // Shared divider
    logic [DV_W-1:0]  div_num;
    logic [DV_W-1:0]  div_den;
    logic [DV_W-1:0]  div_quo;
    logic             div_rem_nz;
    logic             div_done;
    logic             div_busy;
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [NUM_W-1:0]        num_mag;

    assign num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_MEAN_U:
            begin
                div_num = DV_W'({sumu_reg, 8'd0});
                div_den = DV_W'(cntu_reg);
            end
            DIV_MEAN_R:
            begin
                div_num = DV_W'({sumr_reg, 8'd0});
                div_den = DV_W'(cntr_reg);
            end
            DIV_FINAL:
            begin
                div_num = DV_W'(num_mag);
                div_den = DV_W'(den_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    rpcn_div #(
        .DV_W (DV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz),
        .done     (div_done),
        .busy     (div_busy)
    );

    // Means, weighted sums and result
    logic [MEAN_W-1:0]        meanu_reg;
    logic [MEAN_W-1:0]        meanr_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic                     used_reg;
    logic signed [12:0]       diff;
    logic signed [NUM_W:0]    qpos;
    logic signed [NUM_W:0]    qs;
    logic signed [NUM_W:0]    pred_full;
    logic [PRED_W-1:0]        pred_reg;
    logic                     avail_reg;

    assign diff = $signed({1'b0, rw_reg, 8'd0}) - $signed({1'b0, meanr_reg});
    assign qpos = $signed({1'b0, div_quo});
    assign qs   = num_reg[NUM_W-1] ? (-qpos - (NUM_W+1)'(div_rem_nz)) : qpos;
    assign pred_full = qs + $signed((NUM_W+1)'(meanu_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (cmd.clr_pred)
        begin
            used_reg <= 1'b0;
        end
        else if (cmd.acc_num)
        begin
            used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_u)
        begin
            meanu_reg <= MEAN_W'(div_quo);
        end
        if (cmd.take_r)
        begin
            meanr_reg <= MEAN_W'(div_quo);
        end
        if (cmd.mac)
        begin
            term_reg <= TERM_W'($signed({1'b0, s_reg}) * diff);
        end
        if (cmd.clr_pred)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (cmd.acc_num)
        begin
            num_reg <= num_reg + NUM_W'(term_reg);
            den_reg <= den_reg + DEN_W'(s_reg);
        end
        if (cmd.fin)
        begin
            pred_reg  <= pred_full[PRED_W-1:0];
            avail_reg <= !pred_full[NUM_W] && (pred_full != '0);
        end
        else if (cmd.out_zero)
        begin
            pred_reg  <= '0;
            avail_reg <= 1'b0;
        end
    end

    assign prediction = $signed(pred_reg);
    assign available  = avail_reg;

    // Status back to the controller
    always_comb
    begin
        status.su_zero  = (su_reg == '0);
        status.rw_zero  = (rw_reg == '0);
        status.sim_gt   = (s_reg > threshold);
        status.used     = used_reg;
        status.div_done = div_done;
        status.div_busy = div_busy;
    end
endmodule
`default_nettype wire

@@ rtl/core/rpcn_ctrl.sv @@
// Controller state machine: clearing pass, writes and the predict sequence
`default_nettype none
module rpcn_ctrl
    import rpcn_pkg::*;
#(
    parameter int MAX_USERS = DEF_MAX_USERS,
    parameter int MAX_ITEMS = DEF_MAX_ITEMS,
    localparam int RW = $clog2(MAX_USERS),
    localparam int CW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 action,
    input  wire logic [INDEX_W-1:0]   user,
    input  wire logic [INDEX_W-1:0]   item,
    input  wire logic [RATING_W-1:0]  rating,
    input  wire logic [CNT_CFG_W-1:0] users_in_use,
    input  wire logic [CNT_CFG_W-1:0] items_in_use,
    output logic                      busy,
    output logic                      result_valid,
    output cmd_t                      cmd,
    input  wire status_t              status,
    output logic [RW-1:0]             rd_row_a,
    output logic [CW-1:0]             rd_col_a,
    output logic [RW-1:0]             rd_row_b,
    output logic [CW-1:0]             rd_col_b,
    output logic [RW-1:0]             wr_row,
    output logic [CW-1:0]             wr_col,
    output logic [RATING_W-1:0]       wr_data,
    output logic [3:0]                sq_bit
);
    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int UW = $clog2(MAX_USERS + 1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_UROW, ST_UDRAIN, ST_UCHK, ST_UWAIT,
        ST_RSEL, ST_RWAIT, ST_RCHK, ST_PAIR, ST_PDRAIN, ST_PREP,
        ST_SQ1, ST_SQ2, ST_SQ3, ST_SIMCHK, ST_RDIVW, ST_MAC, ST_ACC,
        ST_FDIV, ST_FWAIT, ST_ZERO
    } state_t;

    state_t               state_reg;
    logic [UW-1:0]        r_reg;
    logic [IW-1:0]        e_reg;
    logic [3:0]           b_reg;
    logic [INDEX_W-1:0]   u_reg;
    logic [INDEX_W-1:0]   w_reg;
    logic                 busy_reg;
    logic                 valid_reg;

    // Effective row and column counts
    logic [UW-1:0] nu;
    logic [IW-1:0] ni;
    logic [IW-1:0] ni_m1;
    logic          accept;
    logic          in_store;
    logic          in_use;
    logic          r_is_u;
    logic          r_end;

    assign nu = (CMP_W'(users_in_use) > CMP_W'(MAX_USERS)) ? UW'(MAX_USERS)
                                                             : UW'(users_in_use);
    assign ni = (CMP_W'(items_in_use) > CMP_W'(MAX_ITEMS)) ? IW'(MAX_ITEMS)
                                                             : IW'(items_in_use);
    assign ni_m1    = ni - 1'b1;
    assign accept   = start && !busy_reg;
    assign in_store = (CMP_W'(user) < CMP_W'(MAX_USERS)) &&
                      (CMP_W'(item) < CMP_W'(MAX_ITEMS));
    assign in_use   = (CMP_W'(user) < CMP_W'(nu)) && (CMP_W'(item) < CMP_W'(ni));
    assign r_is_u   = (CMP_W'(r_reg) == CMP_W'(u_reg));
    assign r_end    = (r_reg >= nu);

    // Addresses
    always_comb
    begin
        rd_row_a = RW'(u_reg);
        rd_col_a = e_reg[CW-1:0];
        rd_row_b = r_reg[RW-1:0];
        rd_col_b = (state_reg == ST_RSEL) ? CW'(w_reg) : e_reg[CW-1:0];
        if (state_reg == ST_CLEAR)
        begin
            wr_row  = r_reg[RW-1:0];
            wr_col  = e_reg[CW-1:0];
            wr_data = '0;
        end
        else
        begin
            wr_row  = RW'(user);
            wr_col  = CW'(item);
            wr_data = rating;
        end
        sq_bit = b_reg;
    end

    // Commands decoded from state
    always_comb
    begin
        cmd = '0;
        cmd.acc = ACC_NONE;
        cmd.div_sel = DIV_MEAN_U;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.wr_en    = accept && (action == ACT_WRITE) && in_store;
                cmd.clr_u    = accept && (action == ACT_PREDICT);
                cmd.clr_pred = accept && (action == ACT_PREDICT);
            end
            ST_UROW:   cmd.acc = ACC_ROW;
            ST_UDRAIN: cmd.acc = ACC_NONE;
            ST_UCHK:
            begin
                cmd.div_start = !status.su_zero;
                cmd.div_sel   = DIV_MEAN_U;
            end
            ST_UWAIT:  cmd.take_u = status.div_done;
            ST_RSEL:
            begin
                if (!r_end && !r_is_u)
                begin
                    cmd.acc   = ACC_RW;
                    cmd.clr_r = 1'b1;
                end
            end
            ST_RWAIT:  cmd.acc = ACC_NONE;
            ST_RCHK:   cmd.acc = ACC_NONE;
            ST_PAIR:   cmd.acc = ACC_PAIR;
            ST_PDRAIN: cmd.acc = ACC_NONE;
            ST_PREP:   cmd.prep = 1'b1;
            ST_SQ1:    cmd.sq_mul = 1'b1;
            ST_SQ2:    cmd.sq_lhs = 1'b1;
            ST_SQ3:    cmd.sq_cmp = 1'b1;
            ST_SIMCHK:
            begin
                cmd.div_start = status.sim_gt;
                cmd.div_sel   = DIV_MEAN_R;
            end
            ST_RDIVW:  cmd.take_r = status.div_done;
            ST_MAC:    cmd.mac = 1'b1;
            ST_ACC:    cmd.acc_num = 1'b1;
            ST_FDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_FINAL;
            end
            ST_FWAIT:
            begin
                cmd.div_sel = DIV_FINAL;
                cmd.fin     = status.div_done;
            end
            ST_ZERO:   cmd.out_zero = 1'b1;
            default:   cmd.acc = ACC_NONE;
        endcase
    end

    // State, counters and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            r_reg     <= '0;
            e_reg     <= '0;
            b_reg     <= '0;
            u_reg     <= '0;
            w_reg     <= '0;
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (e_reg == IW'(MAX_ITEMS - 1))
                    begin
                        e_reg <= '0;
                        r_reg <= r_reg + 1'b1;
                        if (r_reg == UW'(MAX_USERS - 1))
                        begin
                            r_reg     <= '0;
                            busy_reg  <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        e_reg <= e_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && (action == ACT_PREDICT))
                    begin
                        u_reg    <= user;
                        w_reg    <= item;
                        e_reg    <= '0;
                        busy_reg <= 1'b1;
                        state_reg <= in_use ? ST_UROW : ST_ZERO;
                    end
                end
                ST_UROW:
                begin
                    if (e_reg == ni_m1)
                    begin
                        state_reg <= ST_UDRAIN;
                    end
                    else
                    begin
                        e_reg <= e_reg + 1'b1;
                    end
                end
                ST_UDRAIN: state_reg <= ST_UCHK;
                ST_UCHK:   state_reg <= status.su_zero ? ST_ZERO : ST_UWAIT;
                ST_UWAIT:
                begin
                    if (status.div_done)
                    begin
                        r_reg     <= '0;
                        state_reg <= ST_RSEL;
                    end
                end
                ST_RSEL:
                begin
                    if (r_end)
                    begin
                        state_reg <= status.used ? ST_FDIV : ST_ZERO;
                    end
                    else if (r_is_u)
                    begin
                        r_reg <= r_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_RWAIT;
                    end
                end
                ST_RWAIT:  state_reg <= ST_RCHK;
                ST_RCHK:
                begin
                    e_reg <= '0;
                    if (status.rw_zero)
                    begin
                        r_reg     <= r_reg + 1'b1;
                        state_reg <= ST_RSEL;
                    end
                    else
                    begin
                        state_reg <= ST_PAIR;
                    end
                end
                ST_PAIR:
                begin
                    if (e_reg == ni_m1)
                    begin
                        state_reg <= ST_PDRAIN;
                    end
                    else
                    begin
                        e_reg <= e_reg + 1'b1;
                    end
                end
                ST_PDRAIN: state_reg <= ST_PREP;
                ST_PREP:
                begin
                    b_reg     <= 4'd15;
                    state_reg <= ST_SQ1;
                end
                ST_SQ1:    state_reg <= ST_SQ2;
                ST_SQ2:    state_reg <= ST_SQ3;
                ST_SQ3:
                begin
                    if (b_reg == 4'd0)
                    begin
                        state_reg <= ST_SIMCHK;
                    end
                    else
                    begin
                        b_reg     <= b_reg - 1'b1;
                        state_reg <= ST_SQ1;
                    end
                end
                ST_SIMCHK:
                begin
                    if (status.sim_gt)
                    begin
                        state_reg <= ST_RDIVW;
                    end
                    else
                    begin
                        r_reg     <= r_reg + 1'b1;
                        state_reg <= ST_RSEL;
                    end
                end
                ST_RDIVW:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC:    state_reg <= ST_ACC;
                ST_ACC:
                begin
                    r_reg     <= r_reg + 1'b1;
                    state_reg <= ST_RSEL;
                end
                ST_FDIV:   state_reg <= ST_FWAIT;
                ST_FWAIT:
                begin
                    if (status.div_done)
                    begin
                        valid_reg <= 1'b1;
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ZERO:
                begin
                    valid_reg <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy         = busy_reg;
    assign result_valid = valid_reg;

`ifndef SYNTH
    // A result strobe lasts a single cycle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> !valid_reg)
        else $error("result strobe held for more than one cycle");

    // A result is only presented once the block is free again
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !busy_reg)
        else $error("result strobe while busy");

    // Busy only rises after an accepted command
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(start))
        else $error("busy rose without a start transfer");

    // The divider is never restarted while running
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");
`endif
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the cosine-neighbor rating predictor
`timescale 1ns / 1ps

module testbench;
    import rpcn_pkg::*;

    localparam int NU = DEF_MAX_USERS;
    localparam int NI = DEF_MAX_ITEMS;
    localparam int STALL_LIMIT = 40000;
    localparam int RAND_ITEMS = 1000;

    // One row of the directed stimulus table
    typedef struct packed {
        logic                     act;
        logic [INDEX_W-1:0]       usr;
        logic [INDEX_W-1:0]       itm;
        logic [RATING_W-1:0]      val;
        logic                     typed;
        logic signed [PRED_W-1:0] pred;
        logic                     avail;
    } step_t;

    typedef struct packed {
        logic signed [PRED_W-1:0] pred;
        logic                     avail;
    } forecast_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic action = ACT_WRITE;
    logic [INDEX_W-1:0] user = '0;
    logic [INDEX_W-1:0] item = '0;
    logic [RATING_W-1:0] rating = '0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic busy;
    logic result_valid;
    logic signed [PRED_W-1:0] prediction;
    logic available;
    logic cfg_ready;

    // Predictor state
    logic [RATING_W-1:0] ratings_q [NU][NI];
    int unsigned thr_q;
    int unsigned users_q;
    int unsigned items_q;

    forecast_t pending_forecasts[$];
    int errors = 0;
    int idle_cycles = 0;
    int sender_gap_pct = 0;

    step_t directed_steps [17] = '{
        '{ACT_PREDICT, 4'd0, 4'd0, 4'd0, 1'b1, 14'sd0, 1'b0},   // empty store
        '{ACT_WRITE, 4'd15, 4'd15, 4'd15, 1'b0, 14'sd0, 1'b0},
        '{ACT_WRITE, 4'd0, 4'd0, 4'd15, 1'b0, 14'sd0, 1'b0},
        '{ACT_PREDICT, 4'd0, 4'd15, 4'd0, 1'b1, 14'sd0, 1'b0},  // orthogonal rows
        '{ACT_WRITE, 4'd15, 4'd0, 4'd1, 1'b0, 14'sd0, 1'b0},
        '{ACT_PREDICT, 4'd0, 4'd15, 4'd0, 1'b0, 14'sd0, 1'b0},
        '{ACT_PREDICT, 4'd15, 4'd0, 4'd0, 1'b0, 14'sd0, 1'b0},
        '{ACT_WRITE, 4'd2, 4'd0, 4'd1, 1'b0, 14'sd0, 1'b0},
        '{ACT_WRITE, 4'd3, 4'd0, 4'd15, 1'b0, 14'sd0, 1'b0},
        '{ACT_WRITE, 4'd3, 4'd1, 4'd1, 1'b0, 14'sd0, 1'b0},
        '{ACT_PREDICT, 4'd2, 4'd1, 4'd0, 1'b0, 14'sd0, 1'b0},   // negative result
        '{ACT_PREDICT, 4'd5, 4'd0, 4'd0, 1'b1, 14'sd0, 1'b0},   // target row empty
        '{ACT_WRITE, 4'd3, 4'd1, 4'd0, 1'b0, 14'sd0, 1'b0},
        '{ACT_PREDICT, 4'd2, 4'd1, 4'd0, 1'b1, 14'sd0, 1'b0},   // nobody rated item
        '{ACT_WRITE, 4'd7, 4'd9, 4'd8, 1'b0, 14'sd0, 1'b0},
        '{ACT_PREDICT, 4'd7, 4'd0, 4'd0, 1'b0, 14'sd0, 1'b0},
        '{ACT_PREDICT, 4'd0, 4'd0, 4'd15, 1'b0, 14'sd0, 1'b0}   // rating ignored
    };

    rating_prediction_cosine_neighbors_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .user(user), .item(item), .rating(rating),
        .result_valid(result_valid), .prediction(prediction), .available(available),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Exact Q.15 cosine: largest s with s*s*su*sr <= dot*dot*2^30
    function automatic longint unsigned cosine_q15(input longint unsigned dot,
                                                   input longint unsigned su,
                                                   input longint unsigned sr);
        longint unsigned rhs;
        longint unsigned prod;
        longint unsigned s;
        longint unsigned c;
        rhs = (dot * dot) << 30;
        prod = su * sr;
        s = 0;
        for (int b = 15; b >= 0; b--) begin
            c = s | (64'd1 << b);
            if (c * c * prod <= rhs)
                s = c;
        end
        return s;
    endfunction

    // Row mean in Q.8 over the first n items, unrated entries not counted
    function automatic longint row_mean_q8(input int r, input int n);
        longint sum;
        longint cnt;
        sum = 0;
        cnt = 0;
        for (int e = 0; e < n; e++) begin
            sum += ratings_q[r][e];
            if (ratings_q[r][e] != 0)
                cnt++;
        end
        return (cnt == 0) ? 0 : (256 * sum) / cnt;
    endfunction

    function automatic forecast_t forecast_rating(input int u, input int w);
        forecast_t f;
        int nu;
        int ni;
        longint su;
        longint dot;
        longint sr;
        longint num;
        longint den;
        longint q;
        longint pred;
        longint unsigned sim;
        bit used;
        nu = (users_q > NU) ? NU : users_q;
        ni = (items_q > NI) ? NI : items_q;
        su = 0;
        num = 0;
        den = 0;
        pred = 0;
        used = 0;
        if (u < nu && w < ni) begin
            for (int e = 0; e < ni; e++)
                su += ratings_q[u][e] * ratings_q[u][e];
            if (su != 0) begin
                for (int r = 0; r < nu; r++) begin
                    if (r == u || ratings_q[r][w] == 0)
                        continue;
                    dot = 0;
                    sr = 0;
                    for (int e = 0; e < ni; e++) begin
                        dot += ratings_q[u][e] * ratings_q[r][e];
                        sr += ratings_q[r][e] * ratings_q[r][e];
                    end
                    sim = cosine_q15(dot, su, sr);
                    if (sim > thr_q) begin
                        num += longint'(sim) * (256 * ratings_q[r][w] - row_mean_q8(r, ni));
                        den += sim;
                        used = 1;
                    end
                end
            end
            if (used && den > 0) begin
                // floor division
                q = num / den;
                if (num % den != 0 && num < 0)
                    q--;
                pred = row_mean_q8(u, ni) + q;
            end else begin
                used = 0;
            end
        end
        f.pred = pred[PRED_W-1:0];
        f.avail = used && pred > 0;
        return f;
    endfunction

    // Drive one item and hold it until the transfer; start stays high after it
    task automatic send_item(input logic act, input logic [INDEX_W-1:0] u,
                             input logic [INDEX_W-1:0] w, input logic [RATING_W-1:0] v,
                             input bit typed, input forecast_t typed_fc);
        start <= 1'b1;
        action <= act;
        user <= u;
        item <= w;
        rating <= v;
        do
            @(posedge clk);
        while (busy);
        if (act == ACT_WRITE) begin
            ratings_q[u][w] = v;
        end else begin
            pending_forecasts.push_back(typed ? typed_fc
                                              : forecast_rating(int'(u), int'(w)));
        end
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < sender_gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // Register write once the block has drained
    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        start <= 1'b0;
        while (pending_forecasts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD: thr_q = value & 32'hFFFF;
            CFG_USERS:     users_q = value & 32'h1F;
            default:       items_q = value & 32'h1F;
        endcase
    endtask

    // Result checking
    always @(posedge clk) begin
        forecast_t exp_fc;
        if (rst_n && result_valid) begin
            if (pending_forecasts.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d/%0d", prediction, available));
            end else begin
                exp_fc = pending_forecasts.pop_front();
                if (prediction !== exp_fc.pred)
                    report_mismatch($sformatf("prediction %0d, expected %0d",
                                              prediction, exp_fc.pred));
                if (available !== exp_fc.avail)
                    report_mismatch($sformatf("available %0b, expected %0b",
                                              available, exp_fc.avail));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int thr_set [6];
        int users_set [6];
        int items_set [6];
        int nu;
        int ni;
        int per_phase;
        forecast_t none_fc;
        for (int r = 0; r < NU; r++)
            for (int e = 0; e < NI; e++)
                ratings_q[r][e] = '0;
        thr_q = 0;
        users_q = 16;
        items_q = 16;
        none_fc = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // Directed part under reset settings
        foreach (directed_steps[k]) begin
            send_item(directed_steps[k].act, directed_steps[k].usr, directed_steps[k].itm,
                      directed_steps[k].val, directed_steps[k].typed,
                      '{directed_steps[k].pred, directed_steps[k].avail});
        end

        // Setting sequence, extremes included
        thr_set = '{0, 32768, 16000, 65535, 0, int'($urandom_range(30000))};
        users_set = '{16, 1, 31, 0, 6, int'($urandom_range(16, 2))};
        items_set = '{16, 16, 20, 1, 4, 0};
        per_phase = RAND_ITEMS / 6;
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_THRESHOLD, thr_set[p]);
            write_reg(CFG_USERS, users_set[p]);
            write_reg(CFG_ITEMS, items_set[p]);
            sender_gap_pct = (p < 2) ? 9 : (p < 4) ? 66 : 0;
            nu = (users_q > NU || users_q == 0) ? NU : users_q;
            ni = (items_q > NI || items_q == 0) ? NI : items_q;
            for (int k = 0; k < per_phase; k++) begin
                sender_gap();
                if ($urandom_range(99) < 65) begin
                    // writes mostly inside the active area, zero now and then
                    send_item(ACT_WRITE,
                              INDEX_W'(($urandom_range(9) == 0) ? $urandom_range(NU - 1)
                                                                : $urandom_range(nu - 1)),
                              INDEX_W'(($urandom_range(9) == 0) ? $urandom_range(NI - 1)
                                                                : $urandom_range(ni - 1)),
                              ($urandom_range(7) == 0) ? 4'd0
                                                       : RATING_W'($urandom_range(15)),
                              1'b0, none_fc);
                end else begin
                    send_item(ACT_PREDICT,
                              INDEX_W'(($urandom_range(9) == 0) ? $urandom_range(NU - 1)
                                                                : $urandom_range(nu - 1)),
                              INDEX_W'(($urandom_range(9) == 0) ? $urandom_range(NI - 1)
                                                                : $urandom_range(ni - 1)),
                              RATING_W'($urandom_range(15)), 1'b0, none_fc);
                end
            end
        end

        // Drain
        start <= 1'b0;
        while (pending_forecasts.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rpcn_pkg.sv
rtl/core/rpcn_div.sv
rtl/core/rpcn_datapath.sv
rtl/core/rpcn_ctrl.sv
rtl/core/rating_prediction_cosine_neighbors_unit.sv
test/testbench.sv
